### design/rcsfe_pkg.sv
// Shared types, constants and the CRC8 step for the RC serial frame encoder.
`timescale 1ns / 1ps

package rcsfe_pkg;

  localparam int MAX_INPUTS = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W = 3;

  localparam logic [CFG_INDEX_W-1:0] CFG_PROTOCOL = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_THROTTLE = 1'b1;

  localparam logic [1:0] PROTO_IBUS = 2'd0;
  localparam logic [1:0] PROTO_SBUS = 2'd1;
  localparam logic [1:0] PROTO_CRSF = 2'd2;
  localparam logic [1:0] PROTO_NONE = 2'd3;

  localparam logic [1:0] PROTOCOL_RESET = PROTO_IBUS;
  localparam logic [2:0] THROTTLE_RESET = 3'd2;

  localparam logic [15:0] PULSE_MIN = 16'd1000;
  localparam logic [15:0] PULSE_MID = 16'd1500;
  localparam logic [15:0] PULSE_MAX = 16'd2000;
  localparam logic [10:0] PACKED_MID = 11'd992;
  // ceil(819 * 2^18 / 500): exact floor(d * 819 / 500) for d up to 500
  localparam logic [18:0] SCALE_MUL = 19'd429392;
  localparam int SCALE_SHIFT = 18;

  localparam logic [7:0] IBUS_HDR0 = 8'h20;
  localparam logic [7:0] IBUS_HDR1 = 8'h40;
  localparam logic [7:0] SBUS_HDR = 8'h0F;
  localparam logic [7:0] SBUS_FAILSAFE = 8'h08;
  localparam logic [7:0] CRSF_ADDR = 8'hC8;
  localparam logic [7:0] CRSF_LEN = 8'd24;
  localparam logic [7:0] CRSF_TYPE = 8'h16;
  localparam logic [7:0] CRC_POLY = 8'hD5;

  typedef struct packed {
    logic [15:0] channel_0;
    logic [15:0] channel_1;
    logic [15:0] channel_2;
    logic [15:0] channel_3;
    logic [15:0] channel_4;
    logic [15:0] channel_5;
    logic [15:0] channel_6;
    logic [15:0] channel_7;
    logic        failsafe;
  } in_data_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } out_data_t;

  typedef struct packed {
    logic [1:0] protocol;
    logic       failsafe;
  } frame_ctl_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    for (int b = 0; b < 8; b++) begin
      r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    end
    return r;
  endfunction

endpackage

### design/rc_serial_frame_encoder.sv
// Top level of the RC serial frame encoder (iBUS, SBUS, CRSF).
//
//   channel  direction  payload                     transfer when
//   in_      input      rcsfe_pkg::in_data_t        in_valid & in_ready
//   out_     output     rcsfe_pkg::out_data_t       out_valid & out_ready
//   cfg_     input      cfg_index, cfg_data         cfg_valid & cfg_ready
//
// Output: one frame byte per cycle while out_ready is high; a frame is 32 (iBUS), 25 (SBUS)
// or 26 (CRSF) bytes, set by the byte serializer. The front scales one channel per cycle through
// one multiplier, min(INPUT_CHANNELS, 8) channels per item, then pushes the item, overlapped
// with output through a two-entry queue; the next item is taken in the push state.
// Dropped items (failsafe in iBUS/CRSF, protocol 3) are accepted at the front and not queued.
// Reset is synchronous active low; no clearing pass. cfg_ready is always high.
// Output back-pressure stalls the serializer, then the queue, then in_ready.
`timescale 1ns / 1ps

module rc_serial_frame_encoder #(
  parameter int INPUT_CHANNELS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rcsfe_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rcsfe_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  rcsfe_pkg::in_data_t               in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output rcsfe_pkg::out_data_t              out_data
);

  localparam int NCH = (INPUT_CHANNELS < rcsfe_pkg::MAX_INPUTS) ?
                       INPUT_CHANNELS : rcsfe_pkg::MAX_INPUTS;
  localparam int DW = $bits(rcsfe_pkg::frame_ctl_t) + NCH * 16;

  logic          push_valid, push_ready;
  logic [DW-1:0] push_data;
  logic          pop_valid, pop_ready;
  logic [DW-1:0] pop_data;

  rcsfe_front #(
    .NCH (NCH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  rcsfe_queue #(
    .WIDTH (DW),
    .DEPTH (rcsfe_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  rcsfe_back #(
    .NCH (NCH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### design/rcsfe_queue.sv
// Short FIFO between the channel scaler and the byte serializer.
`timescale 1ns / 1ps

module rcsfe_queue #(
  parameter int WIDTH = 131,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign push_ready = cnt_r != CW'(DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("queue occupancy above depth");
`endif

endmodule

### design/rcsfe_front.sv
// Front end: config registers, item intake, failsafe substitution and channel scaling.
`timescale 1ns / 1ps

module rcsfe_front #(
  parameter int NCH = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rcsfe_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [rcsfe_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  rcsfe_pkg::in_data_t                 in_data,
  output logic                                push_valid,
  input  logic                                push_ready,
  output logic [$bits(rcsfe_pkg::frame_ctl_t)+NCH*16-1:0] push_data
);

  localparam int CW = (NCH > 1) ? $clog2(NCH) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [CW-1:0]         scan_idx_r, scan_idx_nxt;
  logic [1:0]            protocol_r;
  logic [2:0]            throttle_r;
  rcsfe_pkg::in_data_t   in_r;
  rcsfe_pkg::frame_ctl_t ctl_r;
  logic [NCH-1:0][15:0]  vals_r;

  logic                  accept, drop, scan_last;
  logic [7:0][15:0]      ch_arr;
  logic [2:0]            sel;
  logic [15:0]           v_sub, v_clamp;
  logic                  pos;
  logic [8:0]            delta;
  logic [27:0]           prod;
  logic [9:0]            q;
  logic [10:0]           scaled;
  logic [15:0]           val_cur;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      protocol_r <= rcsfe_pkg::PROTOCOL_RESET;
      throttle_r <= rcsfe_pkg::THROTTLE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rcsfe_pkg::CFG_PROTOCOL: protocol_r <= cfg_data[1:0];
        rcsfe_pkg::CFG_THROTTLE: throttle_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  assign accept     = in_valid && in_ready;
  assign drop       = (protocol_r == rcsfe_pkg::PROTO_NONE) ||
                      (in_data.failsafe && protocol_r != rcsfe_pkg::PROTO_SBUS);
  assign in_ready   = (state_r == ST_IDLE) || (state_r == ST_PUSH && push_ready);
  assign push_valid = state_r == ST_PUSH;
  assign push_data  = {ctl_r, vals_r};
  assign scan_last  = scan_idx_r == CW'(NCH - 1);

  always_comb begin
    state_nxt    = state_r;
    scan_idx_nxt = scan_idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && !drop) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        scan_idx_nxt = scan_idx_r + 1'b1;
        if (scan_last) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (push_ready) begin
          state_nxt = (accept && !drop) ? ST_SCAN : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (accept) begin
      scan_idx_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      scan_idx_r <= '0;
    end else begin
      state_r    <= state_nxt;
      scan_idx_r <= scan_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_r           <= in_data;
      ctl_r.protocol <= protocol_r;
      ctl_r.failsafe <= in_data.failsafe;
    end
  end

  assign ch_arr[0] = in_r.channel_0;
  assign ch_arr[1] = in_r.channel_1;
  assign ch_arr[2] = in_r.channel_2;
  assign ch_arr[3] = in_r.channel_3;
  assign ch_arr[4] = in_r.channel_4;
  assign ch_arr[5] = in_r.channel_5;
  assign ch_arr[6] = in_r.channel_6;
  assign ch_arr[7] = in_r.channel_7;

  // one channel per cycle through a single constant multiplier
  always_comb begin
    sel = 3'(scan_idx_r);
    if (in_r.failsafe) begin
      v_sub = (throttle_r == sel) ? rcsfe_pkg::PULSE_MIN : rcsfe_pkg::PULSE_MID;
    end else begin
      v_sub = ch_arr[sel];
    end
    if (v_sub < rcsfe_pkg::PULSE_MIN) begin
      v_clamp = rcsfe_pkg::PULSE_MIN;
    end else if (v_sub > rcsfe_pkg::PULSE_MAX) begin
      v_clamp = rcsfe_pkg::PULSE_MAX;
    end else begin
      v_clamp = v_sub;
    end
    pos    = v_clamp >= rcsfe_pkg::PULSE_MID;
    delta  = pos ? 9'(v_clamp - rcsfe_pkg::PULSE_MID) : 9'(rcsfe_pkg::PULSE_MID - v_clamp);
    prod   = 28'(delta) * 28'(rcsfe_pkg::SCALE_MUL);
    q      = prod[rcsfe_pkg::SCALE_SHIFT +: 10];
    scaled = pos ? (rcsfe_pkg::PACKED_MID + 11'(q)) : (rcsfe_pkg::PACKED_MID - 11'(q));
    val_cur = (ctl_r.protocol == rcsfe_pkg::PROTO_IBUS) ? v_sub : 16'(scaled);
  end

  for (genvar i = 0; i < NCH; i++) begin : g_lane
    always_ff @(posedge clk) begin
      if (state_r == ST_SCAN && scan_idx_r == CW'(i)) begin
        vals_r[i] <= val_cur;
      end
    end
  end

`ifndef ASSERT_OFF
  a_push_kind: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |-> (ctl_r.protocol != rcsfe_pkg::PROTO_NONE) &&
                   (!ctl_r.failsafe || ctl_r.protocol == rcsfe_pkg::PROTO_SBUS))
    else $error("queued a frame that should have been dropped");
`endif

endmodule

### design/rcsfe_back.sv
// Back end: serializes one queued frame into protocol bytes with checksum (iBUS) or CRC (CRSF).
`timescale 1ns / 1ps

module rcsfe_back #(
  parameter int NCH = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   pop_valid,
  output logic                   pop_ready,
  input  logic [$bits(rcsfe_pkg::frame_ctl_t)+NCH*16-1:0] pop_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output rcsfe_pkg::out_data_t   out_data
);

  localparam int DW = $bits(rcsfe_pkg::frame_ctl_t) + NCH * 16;

  logic                  active_r, active_nxt;
  logic [4:0]            idx_r, idx_nxt;
  logic [DW-1:0]         desc_r;
  logic [15:0]           sum_r;
  logic [7:0]            crc_r;
  logic                  out_valid_r, out_valid_nxt;
  rcsfe_pkg::out_data_t  out_data_r;

  rcsfe_pkg::frame_ctl_t ctl;
  logic [NCH-1:0][15:0]  vals;
  logic [15:0][10:0]     pch;
  logic [31:0][7:0]      pkb;
  logic [15:0][15:0]     ibch;
  logic [3:0]            ib_sel;
  logic [15:0]           ib_word;
  logic [7:0]            byte_cur;
  logic                  last;
  logic                  out_load;

  assign ctl  = desc_r[DW-1 -: $bits(rcsfe_pkg::frame_ctl_t)];
  assign vals = desc_r[NCH*16-1:0];

  for (genvar c = 0; c < 16; c++) begin : g_ch
    if (c < NCH) begin : g_in
      assign pch[c]  = vals[c][10:0];
      assign ibch[c] = vals[c];
    end else begin : g_fix
      assign pch[c]  = rcsfe_pkg::PACKED_MID;
      assign ibch[c] = rcsfe_pkg::PULSE_MID;
    end
  end

  assign pkb     = {80'h0, pch};
  assign ib_sel  = 4'((idx_r - 5'd2) >> 1);
  assign ib_word = ibch[ib_sel];

  always_comb begin
    byte_cur = 8'h00;
    last     = 1'b0;
    unique case (ctl.protocol)
      rcsfe_pkg::PROTO_IBUS: begin
        last = idx_r == 5'd31;
        if (idx_r == 5'd0) begin
          byte_cur = rcsfe_pkg::IBUS_HDR0;
        end else if (idx_r == 5'd1) begin
          byte_cur = rcsfe_pkg::IBUS_HDR1;
        end else if (idx_r < 5'd30) begin
          byte_cur = idx_r[0] ? ib_word[15:8] : ib_word[7:0];
        end else if (idx_r == 5'd30) begin
          byte_cur = ~sum_r[7:0];
        end else begin
          byte_cur = ~sum_r[15:8];
        end
      end
      rcsfe_pkg::PROTO_SBUS: begin
        last = idx_r == 5'd24;
        if (idx_r == 5'd0) begin
          byte_cur = rcsfe_pkg::SBUS_HDR;
        end else if (idx_r < 5'd23) begin
          byte_cur = pkb[idx_r - 5'd1];
        end else if (idx_r == 5'd23) begin
          byte_cur = ctl.failsafe ? rcsfe_pkg::SBUS_FAILSAFE : 8'h00;
        end else begin
          byte_cur = 8'h00;
        end
      end
      rcsfe_pkg::PROTO_CRSF: begin
        last = idx_r == 5'd25;
        if (idx_r == 5'd0) begin
          byte_cur = rcsfe_pkg::CRSF_ADDR;
        end else if (idx_r == 5'd1) begin
          byte_cur = rcsfe_pkg::CRSF_LEN;
        end else if (idx_r == 5'd2) begin
          byte_cur = rcsfe_pkg::CRSF_TYPE;
        end else if (idx_r < 5'd25) begin
          byte_cur = pkb[idx_r - 5'd3];
        end else begin
          byte_cur = crc_r;
        end
      end
      default: last = 1'b1;
    endcase
  end

  assign out_load  = active_r && (!out_valid_r || out_ready);
  assign pop_ready = !active_r || (out_load && last);

  always_comb begin
    active_nxt    = active_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = idx_r + 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (pop_ready) begin
      active_nxt = pop_valid;
      idx_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      desc_r <= pop_data;
    end
    if (out_load) begin
      out_data_r.frame_byte <= byte_cur;
      out_data_r.frame_end  <= last;
      // checksum covers the header and channel bytes only
      if (idx_r < 5'd30) begin
        sum_r <= ((idx_r == 5'd0) ? 16'h0 : sum_r) + 16'(byte_cur);
      end
      crc_r <= rcsfe_pkg::crc8_byte(((idx_r == 5'd2) ? 8'h00 : crc_r) ^ byte_cur);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> idx_r <= 5'd31 &&
      (ctl.protocol != rcsfe_pkg::PROTO_SBUS || idx_r <= 5'd24) &&
      (ctl.protocol != rcsfe_pkg::PROTO_CRSF || idx_r <= 5'd25))
    else $error("byte index ran past frame length");

  a_first_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && idx_r == 5'd0 |=>
      out_data_r.frame_byte == rcsfe_pkg::IBUS_HDR0 ||
      out_data_r.frame_byte == rcsfe_pkg::SBUS_HDR ||
      out_data_r.frame_byte == rcsfe_pkg::CRSF_ADDR)
    else $error("frame did not open with a header byte");

  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_data_r.frame_end == (idx_r == 5'd0 || !active_r))
    else $error("frame end flag out of step with byte index");
`endif

endmodule
